// ----- design/sirt_pkg.sv -----
package sirt_pkg;

  localparam int unsigned SLOTS_DEF       = 1024;
  localparam int unsigned HANDLE_BITS_DEF = 48;
  localparam int unsigned ID_W            = 31;
  localparam int unsigned CAP_W           = 11;
  localparam int unsigned CFG_DATA_W      = 31;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned OUT_HANDLE_W    = 48;

  localparam logic [CAP_W-1:0] CAP_RESET   = 11'd1024;
  localparam logic [ID_W-1:0]  LIMIT_RESET = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_REUSE  = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_WRITE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_COLLECTED = 2'd1,
    ST_EXPIRED   = 2'd2,
    ST_NULL      = 2'd3
  } status_t;

  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_LIMIT    = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR, S_BOUND, S_IDLE, S_SCAN, S_SCAN_WAIT, S_SLOTMOD, S_ALLOC,
    S_LOOK_RD, S_LOOK_WAIT, S_MODID, S_DONE
  } fsm_t;

endpackage

// ----- design/sirt_ram.sv -----
module sirt_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/serial_id_ring_table_top.sv -----
// Serial id ring table.
// Input channel: start/busy command handshake. An item (in_opcode, in_object_handle,
// in_lookup_id, in_slot_index) is taken at a clock edge with start high and busy low.
// Result channel: out_valid is high for exactly one cycle with out_result_id,
// out_result_handle and out_status; the receiver cannot stall, one result per item.
// Configuration: cfg_we/cfg_index/cfg_data; index 0 ring capacity, 1 serial limit.
// Any known write clears the ring; the block then runs its clearing pass again.
// Overwrite and null rejection go straight to the result strobe; a lookup first tests
// whether the id is live and answers an expired id without reduction; allocate and live
// lookup reduce the serial id modulo capacity (a 31-step restoring reduction, one bit per cycle).
// Reuse reads the slot memory slot by slot (address, then registered data).
// Throughput: one item at a time; busy stays high until the result, and the next
// item can be taken at the edge that ends the result cycle.
// The single-port-read slot memory and the bit-serial reducer set the length of each path.
// The effective serial bound (limit rounded down to a multiple of capacity, but at
// least capacity) is worked out bit-serially after each clear.
// Reset: a clearing pass writes every slot to null; busy is high meanwhile and no
// item is accepted.
module serial_id_ring_table_top #(
  parameter int unsigned SLOTS       = sirt_pkg::SLOTS_DEF,
  parameter int unsigned HANDLE_BITS = sirt_pkg::HANDLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_opcode,
  input  logic [HANDLE_BITS-1:0]         in_object_handle,
  input  logic [sirt_pkg::ID_W-1:0]      in_lookup_id,
  input  logic [9:0]                     in_slot_index,
  output logic                           out_valid,
  output logic [sirt_pkg::ID_W-1:0]      out_result_id,
  output logic [sirt_pkg::OUT_HANDLE_W-1:0] out_result_handle,
  output logic [1:0]                     out_status,
  input  logic                           cfg_we,
  input  logic [sirt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sirt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sirt_pkg::*;

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SW = $clog2(SLOTS + 1);
  localparam int unsigned EW = ID_W + 1;
  localparam int unsigned OW = (HANDLE_BITS < OUT_HANDLE_W) ? HANDLE_BITS : OUT_HANDLE_W;

  // configuration
  logic [CAP_W-1:0] cap_reg_r;
  logic [ID_W-1:0]  lim_r;
  logic [ID_W-1:0]  cap;
  always_comb begin
    if (cap_reg_r == '0) cap = ID_W'(1);
    else if (32'(cap_reg_r) > SLOTS) cap = ID_W'(SLOTS);
    else cap = ID_W'(cap_reg_r);
  end

  // state
  fsm_t              st_r, st_nxt;
  logic [SW-1:0]     ptr_r, ptr_nxt;
  logic [ID_W-1:0]   ns_r, ns_nxt;
  logic              wrap_r, wrap_nxt;
  logic [ID_W-1:0]   bound_r, bound_nxt;
  // bit-serial reducer: rem = x mod cap
  logic [ID_W-1:0]   dx_r, dx_nxt;
  logic [EW-1:0]     rem_r, rem_nxt;
  logic [4:0]        bit_r, bit_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [HANDLE_BITS-1:0] h_r, h_nxt;
  logic [ID_W-1:0]   lid_r, lid_nxt;
  logic [9:0]        sidx_r, sidx_nxt;
  logic [SW-1:0]     hit_r, hit_nxt;
  logic              ov_r, ov_nxt;
  logic [ID_W-1:0]   oid_r, oid_nxt;
  logic [OUT_HANDLE_W-1:0] oh_r, oh_nxt;
  logic [1:0]        ost_r, ost_nxt;

  // memory
  logic                   we;
  logic [AW-1:0]          waddr, raddr;
  logic [HANDLE_BITS-1:0] wdata, rdata;

  sirt_ram #(.WIDTH(HANDLE_BITS), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic cfg_hit;
  assign cfg_hit = cfg_we;
  assign busy = (st_r != S_IDLE) || cfg_hit;

  // one restoring step of the reducer
  logic [EW-1:0] rem_sh;
  assign rem_sh = {rem_r[EW-2:0], dx_r[ID_W-1]};

  // live test of lookup id
  logic live;
  always_comb begin
    if (lid_r >= bound_r) live = 1'b0;
    else if (wrap_r && ns_r < cap) begin
      live = (lid_r < ns_r) || (lid_r >= bound_r - (cap - ns_r));
    end else if (lid_r >= ns_r) live = 1'b0;
    else if (ns_r >= cap) live = lid_r >= ns_r - cap;
    else live = 1'b1;
  end

  logic [ID_W-1:0] ns_inc, hit_id, split;
  logic [ID_W-1:0] hit_ext;
  assign ns_inc  = ns_r + ID_W'(1);
  assign hit_ext = ID_W'(hit_r);
  assign split   = rem_r[ID_W-1:0];
  always_comb begin
    if (wrap_r) hit_id = (hit_ext < ns_r) ? hit_ext : bound_r - cap + hit_ext;
    else if (hit_ext < split) hit_id = ns_r - split + hit_ext;
    else hit_id = ns_r - cap - split + hit_ext;
  end

  always_comb begin
    st_nxt = st_r; ptr_nxt = ptr_r; ns_nxt = ns_r; wrap_nxt = wrap_r;
    bound_nxt = bound_r; dx_nxt = dx_r; rem_nxt = rem_r; bit_nxt = bit_r;
    op_nxt = op_r; h_nxt = h_r; lid_nxt = lid_r; sidx_nxt = sidx_r; hit_nxt = hit_r;
    ov_nxt = 1'b0; oid_nxt = oid_r; oh_nxt = oh_r; ost_nxt = ost_r;
    we = 1'b0; waddr = ptr_r[AW-1:0]; wdata = '0; raddr = ptr_r[AW-1:0];

    // reducer step shared by bound, split, allocation slot and lookup slot
    if (st_r == S_BOUND || st_r == S_MODID) begin
      if (rem_sh >= EW'(cap)) rem_nxt = rem_sh - EW'(cap);
      else rem_nxt = rem_sh;
      dx_nxt = dx_r << 1;
      bit_nxt = bit_r - 5'd1;
    end

    case (st_r)
      S_CLEAR: begin
        we = 1'b1;
        ptr_nxt = ptr_r + SW'(1);
        if (ptr_r == SW'(SLOTS - 1)) begin
          st_nxt = S_BOUND; dx_nxt = lim_r; rem_nxt = '0; bit_nxt = 5'(ID_W - 1);
        end
      end
      S_BOUND: begin
        if (bit_r == 5'd0) begin
          if (lim_r - rem_nxt[ID_W-1:0] < cap) bound_nxt = cap;
          else bound_nxt = lim_r - rem_nxt[ID_W-1:0];
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt = in_opcode; h_nxt = in_object_handle; lid_nxt = in_lookup_id;
          sidx_nxt = in_slot_index; ptr_nxt = '0;
          oid_nxt = '0; oh_nxt = '0; ost_nxt = ST_OK;
          case (op_t'(in_opcode))
            OP_ALLOC, OP_REUSE: begin
              if (in_object_handle == '0) begin
                ost_nxt = ST_NULL; st_nxt = S_DONE;
              end else if (in_opcode == OP_REUSE) st_nxt = S_SCAN;
              else st_nxt = S_ALLOC;
            end
            OP_LOOKUP: st_nxt = S_LOOK_RD;
            default:   st_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        raddr = ptr_r[AW-1:0];
        st_nxt = S_SCAN_WAIT;
      end
      S_SCAN_WAIT: begin
        if (rdata == h_r) begin
          hit_nxt = ptr_r;
          if (!wrap_r && ID_W'(ptr_r) >= ns_r) st_nxt = S_ALLOC;
          else begin
            st_nxt = S_MODID; dx_nxt = ns_r; rem_nxt = '0; bit_nxt = 5'(ID_W - 1);
          end
        end else if (ID_W'(ptr_r) + ID_W'(1) >= cap) st_nxt = S_ALLOC;
        else begin
          ptr_nxt = ptr_r + SW'(1); st_nxt = S_SCAN;
        end
      end
      S_MODID: begin
        if (bit_r == 5'd0) st_nxt = (op_r == OP_LOOKUP) ? S_LOOK_WAIT : S_SLOTMOD;
      end
      S_SLOTMOD: begin
        oid_nxt = hit_id; st_nxt = S_DONE;
      end
      S_ALLOC: begin
        // ns mod cap via reducer first
        st_nxt = S_MODID; op_nxt = OP_ALLOC; dx_nxt = ns_r; rem_nxt = '0;
        bit_nxt = 5'(ID_W - 1);
      end
      S_LOOK_RD: begin
        if (!live) begin
          ost_nxt = ST_EXPIRED; st_nxt = S_DONE;
        end else begin
          st_nxt = S_MODID; dx_nxt = lid_r; rem_nxt = '0; bit_nxt = 5'(ID_W - 1);
        end
      end
      S_LOOK_WAIT: begin
        raddr = rem_r[AW-1:0];
        st_nxt = S_DONE; ptr_nxt = SW'(SLOTS);
      end
      S_DONE: begin
        if (op_r == OP_LOOKUP && ost_r == ST_OK && ptr_r == SW'(SLOTS)) begin
          if (rdata == '0) ost_nxt = ST_COLLECTED;
          else oh_nxt = OUT_HANDLE_W'(rdata[OW-1:0]);
          ptr_nxt = '0;
        end else begin
          if (op_r == OP_WRITE && {21'd0, sidx_r} < cap) begin
            we = 1'b1; waddr = AW'(sidx_r); wdata = h_r;
          end
          ov_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    // allocation write after reduction of next serial
    if (st_r == S_MODID && bit_r == 5'd0 && op_r == OP_ALLOC) begin
      st_nxt = S_DONE; op_nxt = OP_REUSE;
      we = 1'b1; waddr = AW'(rem_nxt); wdata = h_r;
      oid_nxt = ns_r;
      if (ns_inc >= bound_r) begin
        ns_nxt = '0; wrap_nxt = 1'b1;
      end else begin
        ns_nxt = ns_inc;
        if (ns_inc >= cap) wrap_nxt = 1'b0;
      end
    end

    if (cfg_hit) begin
      st_nxt = S_CLEAR; ptr_nxt = '0; ns_nxt = '0; wrap_nxt = 1'b0; ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR; ptr_r <= '0; ns_r <= '0; wrap_r <= 1'b0; ov_r <= 1'b0;
      cap_reg_r <= CAP_RESET; lim_r <= LIMIT_RESET; bound_r <= LIMIT_RESET;
    end else begin
      st_r <= st_nxt; ptr_r <= ptr_nxt; ns_r <= ns_nxt; wrap_r <= wrap_nxt;
      ov_r <= ov_nxt; bound_r <= bound_nxt;
      if (cfg_we && cfg_index == CFG_CAPACITY) cap_reg_r <= cfg_data[CAP_W-1:0];
      if (cfg_we && cfg_index == CFG_LIMIT) lim_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= dx_nxt; rem_r <= rem_nxt; bit_r <= bit_nxt; op_r <= op_nxt; h_r <= h_nxt;
    lid_r <= lid_nxt; sidx_r <= sidx_nxt; hit_r <= hit_nxt;
    oid_r <= oid_nxt; oh_r <= oh_nxt; ost_r <= ost_nxt;
  end

  assign out_valid         = ov_r;
  assign out_result_id     = oid_r;
  assign out_result_handle = oh_r;
  assign out_status        = ost_r;

`ifndef SYNTHESIS
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");
  a_busy_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CLEAR) |-> busy) else $error("idle during clear");
  a_ns_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> (ns_r < bound_r)) else $error("serial past bound");
`endif

endmodule

// ----- sim/id_ring_checker.sv -----
`timescale 1ns / 100ps

module id_ring_checker
  import sirt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic [1:0]              in_opcode,
  input  logic [47:0]             in_object_handle,
  input  logic [ID_W-1:0]         in_lookup_id,
  input  logic [9:0]              in_slot_index,
  input  logic                    out_valid,
  input  logic [ID_W-1:0]         out_result_id,
  input  logic [OUT_HANDLE_W-1:0] out_result_handle,
  input  logic [1:0]              out_status,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [47:0]      handle;
    status_t          status;
  } answer_t;

  logic [47:0]   ring [SLOTS_DEF];
  int unsigned   serial_ctr;
  bit            wrapped;
  int unsigned   cap_reg;
  int unsigned   lim_reg;
  answer_t       answers_due[$];

  function automatic int unsigned cap_used();
    int unsigned c;
    c = cap_reg;
    if (c < 1) c = 1;
    if (c > SLOTS_DEF) c = SLOTS_DEF;
    return c;
  endfunction

  function automatic int unsigned serial_bound();
    int unsigned c, m;
    c = cap_used();
    m = lim_reg - (lim_reg % c);
    if (m < c) m = c;
    return m;
  endfunction

  function automatic void wipe_ring();
    foreach (ring[i]) ring[i] = '0;
    serial_ctr = 0;
    wrapped = 0;
  endfunction

  function automatic bit serial_live(int unsigned id);
    int unsigned c, b;
    c = cap_used();
    b = serial_bound();
    if (id >= b) return 0;
    if (wrapped && serial_ctr < c) begin
      if (id < serial_ctr) return 1;
      return id >= b - (c - serial_ctr);
    end
    if (id >= serial_ctr) return 0;
    if (serial_ctr >= c) return id >= serial_ctr - c;
    return 1;
  endfunction

  // id currently owned by slot i, if any
  function automatic bit slot_serial(int unsigned i, output int unsigned id);
    int unsigned c, split;
    c = cap_used();
    id = 0;
    if (i >= c) return 0;
    if (wrapped) begin
      id = (i < serial_ctr) ? i : serial_bound() - c + i;
      return 1;
    end
    if (i < serial_ctr) begin
      split = serial_ctr % c;
      if (i < split) id = serial_ctr - split + i;
      else id = serial_ctr - c - split + i;
      return 1;
    end
    return 0;
  endfunction

  function automatic int unsigned hand_out(logic [47:0] h);
    int unsigned c, id;
    c = cap_used();
    id = serial_ctr;
    serial_ctr++;
    if (serial_ctr >= serial_bound()) begin
      serial_ctr = 0;
      wrapped = 1;
    end else if (serial_ctr >= c) begin
      wrapped = 0;
    end
    ring[id % c] = h;
    return id;
  endfunction

  function automatic answer_t serve(op_t op, logic [47:0] h, int unsigned lid,
                                    int unsigned sidx);
    answer_t a;
    int unsigned c, id;
    bit found;
    a = '{id: '0, handle: '0, status: ST_OK};
    c = cap_used();
    found = 0;
    case (op)
      OP_ALLOC, OP_REUSE: begin
        if (h == '0) begin
          a.status = ST_NULL;
        end else begin
          if (op == OP_REUSE) begin
            for (int unsigned i = 0; i < c; i++) begin
              if (ring[i] == h) begin
                if (slot_serial(i, id)) begin
                  a.id = id[ID_W-1:0];
                  found = 1;
                end
                break;
              end
            end
          end
          if (!found) a.id = ID_W'(hand_out(h));
        end
      end
      OP_LOOKUP: begin
        if (!serial_live(lid)) a.status = ST_EXPIRED;
        else if (ring[lid % c] == '0) a.status = ST_COLLECTED;
        else a.handle = ring[lid % c];
      end
      default: begin
        if (sidx < c) ring[sidx] = h;
      end
    endcase
    return a;
  endfunction

  assign pending = answers_due.size();

  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst_n) begin
      cap_reg = CAP_RESET;
      lim_reg = LIMIT_RESET;
      wipe_ring();
      answers_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CAPACITY) cap_reg = cfg_data[CAP_W-1:0];
        else lim_reg = cfg_data;
        wipe_ring();
      end
      if (start && !busy)
        answers_due.push_back(serve(op_t'(in_opcode), in_object_handle,
                                    in_lookup_id, in_slot_index));
      if (out_valid) begin
        if (answers_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: id %0d handle %h status %0d",
                     out_result_id, out_result_handle, out_status);
        end else begin
          exp_a = answers_due.pop_front();
          if (out_result_id !== exp_a.id || out_result_handle !== exp_a.handle ||
              out_status !== exp_a.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp id %0d handle %h status %0d, got %0d %h %0d",
                       exp_a.id, exp_a.handle, exp_a.status,
                       out_result_id, out_result_handle, out_status);
          end
        end
      end
    end
  end

endmodule

// ----- sim/serial_id_ring_table_top_test.sv -----
`timescale 1ns / 100ps

module serial_id_ring_table_top_test;
  import sirt_pkg::*;

  localparam int CYCLE_LIMIT = 10_000_000;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [1:0]              in_opcode;
  logic [47:0]             in_object_handle;
  logic [ID_W-1:0]         in_lookup_id;
  logic [9:0]              in_slot_index;
  logic                    out_valid;
  logic [ID_W-1:0]         out_result_id;
  logic [OUT_HANDLE_W-1:0] out_result_handle;
  logic [1:0]              out_status;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  int                      fail_count;
  int                      pending;
  int                      cycles;

  // settings used by the random part to aim at the live window
  int unsigned cur_cap;
  int unsigned cur_lim;

  serial_id_ring_table_top dut (.*);

  id_ring_checker chk (.*);

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one item; start stays high into the next item when no gap follows
  task automatic issue(op_t op, logic [47:0] h, logic [ID_W-1:0] lid,
                       logic [9:0] sidx, int gap);
    start            <= 1'b1;
    in_opcode        <= op;
    in_object_handle <= h;
    in_lookup_id     <= lid;
    in_slot_index    <= sidx;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // register write only once the block has nothing left in flight
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CAPACITY) begin
      cur_cap = val[CAP_W-1:0];
      if (cur_cap < 1) cur_cap = 1;
      if (cur_cap > SLOTS_DEF) cur_cap = SLOTS_DEF;
    end else begin
      cur_lim = val;
    end
  endtask

  function automatic int pick_gap(bit quiet);
    if (quiet) return 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 0;
      4, 5, 6:    return 1;
      7, 8:       return $urandom_range(2, 5);
      default:    return $urandom_range(20, 70);
    endcase
  endfunction

  function automatic logic [47:0] pick_handle();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return 48'({$urandom, $urandom});
      default: return 48'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic random_run(int count);
    op_t         op;
    int unsigned span;
    bit          quiet;
    logic [ID_W-1:0] lid;
    logic [9:0]  sidx;
    span = (cur_lim > 3000) ? 3000 : cur_lim;
    for (int n = 0; n < count; n++) begin
      // stretches with no idling at all
      quiet = ((n / 20) % 3 == 1);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5:       op = OP_ALLOC;
        6, 7, 8, 9, 10, 11:     op = OP_REUSE;
        12, 13, 14, 15, 16:     op = OP_LOOKUP;
        default:                op = OP_WRITE;
      endcase
      if ($urandom_range(0, 6) == 0) lid = ID_W'($urandom);
      else lid = ID_W'($urandom_range(0, span + 4));
      if ($urandom_range(0, 3) == 0) sidx = 10'($urandom);
      else sidx = 10'($urandom_range(0, (cur_cap > 1021) ? 1023 : cur_cap + 2));
      issue(op, pick_handle(), lid, sidx, pick_gap(quiet));
    end
  endtask

  initial begin
    cycles           = 0;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_opcode        = '0;
    in_object_handle = '0;
    in_lookup_id     = '0;
    in_slot_index    = '0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    cur_cap          = CAP_RESET;
    cur_lim          = LIMIT_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset settings: null rejection, extreme handles, reuse hit/miss, lookups, overwrite
    issue(OP_ALLOC,  '0,              '0, '0, 0);
    issue(OP_REUSE,  '0,              '0, '0, 1);
    issue(OP_ALLOC,  48'hFFFF_FFFF_FFFF, '0, '0, 0);
    issue(OP_ALLOC,  48'h1,           '0, '0, 0);
    issue(OP_REUSE,  48'hFFFF_FFFF_FFFF, '0, '0, 2);
    issue(OP_REUSE,  48'hA5A5_5A5A_0F0F, '0, '0, 0);
    issue(OP_LOOKUP, '0, 31'd0,  '0, 0);
    issue(OP_LOOKUP, '0, 31'd1,  '0, 0);
    issue(OP_LOOKUP, '0, 31'd5,  '0, 0);            // not yet handed out
    issue(OP_LOOKUP, '0, 31'h7FFF_FFFF, '0, 0);     // beyond the bound
    issue(OP_WRITE,  '0, '0, 10'd0, 0);             // collect slot 0
    issue(OP_LOOKUP, '0, 31'd0,  '0, 0);            // now collected
    issue(OP_WRITE,  48'h5A5A_A5A5_F0F0, '0, 10'h3FF, 0);
    issue(OP_REUSE,  48'h5A5A_A5A5_F0F0, '0, '0, 3); // found in slot without live id

    // small ring with a tight bound: wraps quickly, overwrite out of range
    set_reg(CFG_CAPACITY, 31'd4);
    set_reg(CFG_LIMIT,    31'd10);
    issue(OP_WRITE,  48'h7, '0, 10'd9, 0);
    issue(OP_LOOKUP, '0, 31'd1, '0, 1);
    random_run(100);

    // capacity zero clamps to one, limit of one
    set_reg(CFG_CAPACITY, 31'd0);
    set_reg(CFG_LIMIT,    31'd1);
    random_run(70);

    // capacity above the table clamps; limit below capacity lifts the bound
    set_reg(CFG_CAPACITY, 31'h7FF);
    set_reg(CFG_LIMIT,    31'd5);
    random_run(60);

    // odd capacity, largest limit
    set_reg(CFG_CAPACITY, 31'd7);
    set_reg(CFG_LIMIT,    31'h7FFF_FFFF);
    random_run(90);

    // limit with a remainder against the capacity
    set_reg(CFG_CAPACITY, 31'd16);
    set_reg(CFG_LIMIT,    31'd37);
    random_run(130);

    // high data bits of the capacity register, then a mid limit
    set_reg(CFG_CAPACITY, 31'h7FFF_F803);
    set_reg(CFG_LIMIT,    31'h2AAA_AAA9);
    random_run(120);

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
